// ===== rtl/core/bhp_pkg.sv =====
// Shared types and constants for the pixel color-space converter.
// The stage record is handed from the front stage through every divider cell.
package bhp_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned Q_W     = 8;   // quotient bits, one per cell
  localparam int unsigned SAT_N_W = 17;  // 510*delta + max
  localparam int unsigned SAT_D_W = 9;   // 2*max
  localparam int unsigned HUE_N_W = 20;  // 510*sum + 6*delta
  localparam int unsigned HUE_D_W = 12;  // 12*delta
  localparam int unsigned SUM_W   = 12;  // signed hue sum before wrap
  localparam int unsigned CELLS   = Q_W;

  // 2*255: numerator scale that folds the half-up rounding into a floor divide
  localparam logic [HUE_N_W-1:0] SCALE2 = HUE_N_W'(510);

  typedef struct packed {
    logic [SAT_N_W-1:0] sat_rem;
    logic [SAT_D_W-1:0] sat_div;
    logic [Q_W-1:0]     sat_q;
    logic [HUE_N_W-1:0] hue_rem;
    logic [HUE_D_W-1:0] hue_div;
    logic [Q_W-1:0]     hue_q;
    logic [PIX_W-1:0]   value;
  } stage_t;

endpackage

// ===== rtl/core/bhp_prep.sv =====
// Front stage: max/min, delta, hue sum and the two dividend/divisor pairs.
// Depends on bhp_pkg for the stage record and field widths.
module bhp_prep (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      blue,
  input  logic [7:0]      green,
  input  logic [7:0]      red,
  output logic            out_valid,
  input  logic            out_ready,
  output bhp_pkg::stage_t out_stage
);
  import bhp_pkg::*;

  logic [PIX_W-1:0] mx;
  logic [PIX_W-1:0] mn;
  logic [PIX_W-1:0] dl;
  logic [SUM_W-1:0] d2;
  logic [SUM_W-1:0] d4;
  logic [SUM_W-1:0] d6;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_w;
  stage_t           stage_nxt;
  stage_t           stage_r;
  logic             valid_r;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    dl = mx - mn;
    d2 = {3'b000, dl, 1'b0};
    d4 = {2'b00, dl, 2'b00};
    d6 = d2 + d4;

    // red wins ties over green, green over blue
    priority if (red == mx) begin
      sum = {4'b0000, green} - {4'b0000, blue};
    end else if (green == mx) begin
      sum = d2 + {4'b0000, blue} - {4'b0000, red};
    end else begin
      sum = d4 + {4'b0000, red} - {4'b0000, green};
    end
    // wrap a negative angle into one full circle
    sum_w = sum[SUM_W-1] ? sum + d6 : sum;

    stage_nxt.value = mx;
    stage_nxt.sat_q = '0;
    stage_nxt.hue_q = '0;
    if (dl == '0) begin
      // gray: divide zero by one so both quotients come out zero
      stage_nxt.sat_rem = '0;
      stage_nxt.sat_div = SAT_D_W'(1);
      stage_nxt.hue_rem = '0;
      stage_nxt.hue_div = HUE_D_W'(1);
    end else begin
      stage_nxt.sat_rem = SAT_N_W'(HUE_N_W'(dl) * SCALE2) + SAT_N_W'(mx);
      stage_nxt.sat_div = {1'b0, mx} << 1;
      stage_nxt.hue_rem = HUE_N_W'(sum_w[SUM_W-2:0]) * SCALE2 + HUE_N_W'(d6);
      stage_nxt.hue_div = HUE_D_W'(d6) << 1;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_stage = stage_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

// ===== rtl/core/bhp_div_cell.sv =====
// One restoring-division cell: settles quotient bit BIT of both dividers.
// Depends on bhp_pkg for the stage record passed between neighbors.
module bhp_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bhp_pkg::stage_t in_stage,
  output logic            out_valid,
  input  logic            out_ready,
  output bhp_pkg::stage_t out_stage
);
  import bhp_pkg::*;

  logic [SAT_N_W-1:0] sat_trial;
  logic [HUE_N_W-1:0] hue_trial;
  logic               sat_take;
  logic               hue_take;
  stage_t             stage_nxt;
  stage_t             stage_r;
  logic               valid_r;

  always_comb begin
    sat_trial = SAT_N_W'(in_stage.sat_div) << BIT;
    hue_trial = HUE_N_W'(in_stage.hue_div) << BIT;
    sat_take  = in_stage.sat_rem >= sat_trial;
    hue_take  = in_stage.hue_rem >= hue_trial;

    stage_nxt = in_stage;
    if (sat_take) stage_nxt.sat_rem = in_stage.sat_rem - sat_trial;
    if (hue_take) stage_nxt.hue_rem = in_stage.hue_rem - hue_trial;
    stage_nxt.sat_q[BIT] = sat_take;
    stage_nxt.hue_q[BIT] = hue_take;
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_stage = stage_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

// ===== rtl/core/bgr_to_hsv_pixel_core.sv =====
// Blue/green/red to hue/saturation/value converter, one 8-bit pixel per beat.
// Takes one pixel every clock unless out_tready backpressure fills the row, and
// returns one result per pixel: one front stage finds max, min and the hue sum, then a row
// of eight restoring-division cells settles one quotient bit each for the
// saturation and hue dividers side by side. Every stage holds its beat under
// backpressure and refills as soon as its neighbor frees, so bubbles close up.
// Depends on bhp_pkg, bhp_prep and bhp_div_cell.
module bgr_to_hsv_pixel_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // blue[7:0], green[15:8], red[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // hue[7:0], saturation[15:8], brightness[23:16]
);
  import bhp_pkg::*;

  stage_t pipe  [0:CELLS];
  logic   valid [0:CELLS];
  logic   ready [0:CELLS];

  bhp_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .blue      (in_tdata[7:0]),
    .green     (in_tdata[15:8]),
    .red       (in_tdata[23:16]),
    .out_valid (valid[0]),
    .out_ready (ready[0]),
    .out_stage (pipe[0])
  );

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    bhp_div_cell #(
      .BIT (CELLS - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (valid[i]),
      .in_ready  (ready[i]),
      .in_stage  (pipe[i]),
      .out_valid (valid[i+1]),
      .out_ready (ready[i+1]),
      .out_stage (pipe[i+1])
    );
  end

  assign ready[CELLS] = out_tready;
  assign out_tvalid   = valid[CELLS];
  assign out_tdata    = {pipe[CELLS].value, pipe[CELLS].sat_q, pipe[CELLS].hue_q};

endmodule

// ===== rtl/core/bhp_checker.sv =====
// Port-level checks for bgr_to_hsv_pixel_core, attached by the bind below.
// Sees only the top-level ports; no package needed.
module bhp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // a stalled pixel beat holds until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("pixel beat changed while stalled");

  // with the last stage empty the whole row can take a beat
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");

  // zero saturation only for gray pixels, which carry zero hue
  a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[15:8] == 8'd0) |-> (out_tdata[7:0] == 8'd0))
    else $error("nonzero hue with zero saturation");

  // black has no saturation
  a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[23:16] == 8'd0) |-> (out_tdata[15:8] == 8'd0))
    else $error("nonzero saturation on black pixel");

endmodule

bind bgr_to_hsv_pixel_core bhp_checker u_bhp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
